// ----- hw/rtl/mhtq_pkg.sv -----
// Package for the min-heap timer queue: payload structs, codes, and the
// command and status types between controller and datapath. No dependencies.
package mhtq_pkg;

	localparam int OP_W      = 2;
	localparam int HANDLE_W  = 10;
	localparam int TIMEOUT_W = 32;
	localparam int NOW_W     = 48;
	localparam int GAP_W     = 48;
	localparam int STATUS_W  = 2;

	localparam int DEF_CAPACITY  = 32;
	localparam int DEF_HANDLES   = 1024;
	localparam int DEF_TIME_BITS = 48;

	// A tick removes at most this many entries.
	localparam int MAX_POPS = 32;
	localparam int POP_W    = $clog2(MAX_POPS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_ADD    = 2'd1,
		OP_ADJUST = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic {
		KIND_EXPIRED = 1'b0,
		KIND_FINAL   = 1'b1
	} kind_t;

	typedef struct packed {
		logic [OP_W-1:0]      operation;
		logic [HANDLE_W-1:0]  handle;
		logic [TIMEOUT_W-1:0] timeout_ms;
		logic [NOW_W-1:0]     now;
	} item_t;

	typedef struct packed {
		logic                 kind;
		logic [HANDLE_W-1:0]  expired_handle;
		logic [GAP_W-1:0]     time_to_next;
		logic [STATUS_W-1:0]  status;
		logic                 last;
	} result_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_MAP_READ,
		CMD_START_ADJ,
		CMD_START_ADD,
		CMD_SET_ABSENT,
		CMD_SET_FULL,
		CMD_READ_PARENT,
		CMD_MOVE_PARENT,
		CMD_READ_LEFT,
		CMD_LATCH_LEFT,
		CMD_LATCH_RIGHT,
		CMD_MOVE_CHILD,
		CMD_WRITE_E,
		CMD_READ_ROOT,
		CMD_POP_ROOT,
		CMD_READ_LAST,
		CMD_START_DOWN,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_tick;
		logic is_none;
		logic is_adjust;
		logic handle_ok;
		logic hit;
		logic full;
		logic k_zero;
		logic less_parent;
		logic moved;
		logic l_ok;
		logic t_is_k;
		logic pops_left;
		logic due;
		logic count_zero;
	} stat_t;

endpackage

// ----- hw/rtl/mhtq_stream_if.sv -----
// Valid/ready channel carrying one payload struct per transaction.
// Depends on mhtq_pkg for the default payload type.
interface mhtq_stream_if #(parameter type payload_t = mhtq_pkg::item_t);
	import mhtq_pkg::*;

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ----- hw/rtl/min_heap_timer_queue.sv -----
// Timer queue kept as a binary min-heap of expiry times in a CAPACITY-entry RAM,
// with a HANDLES-entry RAM mapping each handle to its heap slot. After reset the
// block clears every entry of the handle map and takes no item until it is done.
// One item is worked at a time. The heap RAM has a single read port, so a sift
// step up reads the parent and moves it down if it expires later, and a sift step
// down reads the left child, then the right child, and moves the earlier one up
// if it expires before the entry. Add and adjust look up the handle, sift the
// entry and send the final result. A tick pops each due root entry, sends a notice
// for it and sifts the last entry down from the root, then reads the root for the
// final result. The result port may stall each notice and the final result.
// Uses mhtq_pkg, mhtq_stream_if, mhtq_ctrl, mhtq_datapath.
module min_heap_timer_queue #(
	parameter int CAPACITY  = mhtq_pkg::DEF_CAPACITY,
	parameter int HANDLES   = mhtq_pkg::DEF_HANDLES,
	parameter int TIME_BITS = mhtq_pkg::DEF_TIME_BITS
) (
	input logic          clk,
	input logic          arst_n,
	mhtq_stream_if.sink   item,
	mhtq_stream_if.source result
);
	import mhtq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mhtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	mhtq_datapath #(
		.CAPACITY  (CAPACITY),
		.HANDLES   (HANDLES),
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.item_data   (item.data),
		.result_data (result.data)
	);

endmodule

// ----- hw/rtl/mhtq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mhtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/mhtq_datapath.sv -----
// Datapath of the timer queue: heap and handle map memories, the moving
// entry, slot index, entry count and result registers. Uses mhtq_pkg, mhtq_ram.
module mhtq_datapath #(
	parameter int CAPACITY  = mhtq_pkg::DEF_CAPACITY,
	parameter int HANDLES   = mhtq_pkg::DEF_HANDLES,
	parameter int TIME_BITS = mhtq_pkg::DEF_TIME_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mhtq_pkg::cmd_t    cmd,
	output mhtq_pkg::stat_t   stat,
	input  mhtq_pkg::item_t   item_data,
	output mhtq_pkg::result_t result_data
);
	import mhtq_pkg::*;

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int CHILD_W = IDX_W + 2;
	localparam int MAP_AW  = (HANDLES > 1) ? $clog2(HANDLES) : 1;
	localparam int MAP_W   = IDX_W + 1;
	localparam int HEAP_W  = TIME_BITS + HANDLE_W;
	localparam int SUM_W   = ((TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W) + 1;
	localparam int GAP_DW  = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;
	localparam int HCMP_W  = 17;
	localparam logic [TIME_BITS-1:0] TIME_MASK = '1;
	localparam logic [GAP_W-1:0]     GAP_MAX   = '1;

	// Control state.
	logic [CNT_W-1:0]  count_q;
	logic [MAP_AW-1:0] clr_q;
	logic [POP_W-1:0]  pops_q;

	// Item and moving entry.
	logic [OP_W-1:0]      op_q;
	logic [HANDLE_W-1:0]  h_q;
	logic [TIME_BITS-1:0] exp_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] e_exp_q;
	logic [HANDLE_W-1:0]  e_h_q;
	logic [IDX_W-1:0]     k_q;
	logic [IDX_W-1:0]     start_q;
	logic [IDX_W-1:0]     t_q;
	logic [TIME_BITS-1:0] best_exp_q;
	logic [HANDLE_W-1:0]  best_h_q;
	status_t              status_q;
	result_t              res_q;

	// Memory ports.
	logic              heap_we, heap_re;
	logic [IDX_W-1:0]  heap_waddr, heap_raddr;
	logic [HEAP_W-1:0] heap_wdata, heap_rdata_q;
	logic              map_we, map_re;
	logic [MAP_AW-1:0] map_waddr, map_raddr;
	logic [MAP_W-1:0]  map_wdata, map_rdata_q;

	logic [TIME_BITS-1:0] rd_exp;
	logic [HANDLE_W-1:0]  rd_h;
	logic                 map_valid;
	logic [IDX_W-1:0]     map_slot;
	logic [IDX_W-1:0]     parent;
	logic [CHILD_W-1:0]   left_w, right_w;
	logic                 r_ok;
	logic [TIME_BITS-1:0] in_now;
	logic [SUM_W-1:0]     sum;
	logic [TIME_BITS-1:0] new_exp;
	logic [TIME_BITS-1:0] diff;
	logic [GAP_DW-1:0]    gap_ext;
	logic [GAP_W-1:0]     gap;

	mhtq_ram #(.WIDTH(HEAP_W), .DEPTH(CAPACITY)) u_heap_ram (
		.clk     (clk),
		.we      (heap_we),
		.waddr   (heap_waddr),
		.wdata   (heap_wdata),
		.re      (heap_re),
		.raddr   (heap_raddr),
		.rdata_q (heap_rdata_q)
	);

	mhtq_ram #(.WIDTH(MAP_W), .DEPTH(HANDLES)) u_map_ram (
		.clk     (clk),
		.we      (map_we),
		.waddr   (map_waddr),
		.wdata   (map_wdata),
		.re      (map_re),
		.raddr   (map_raddr),
		.rdata_q (map_rdata_q)
	);

	assign rd_exp    = heap_rdata_q[HEAP_W-1:HANDLE_W];
	assign rd_h      = heap_rdata_q[HANDLE_W-1:0];
	assign map_valid = map_rdata_q[IDX_W];
	assign map_slot  = map_rdata_q[IDX_W-1:0];
	assign parent    = (k_q - IDX_W'(1)) >> 1;
	assign left_w    = CHILD_W'({k_q, 1'b1});
	assign right_w   = CHILD_W'({k_q, 1'b0}) + CHILD_W'(2);
	assign r_ok      = right_w < CHILD_W'(count_q);

	// New expiry, saturated at the top of the time range.
	assign in_now  = TIME_BITS'(item_data.now);
	assign sum     = SUM_W'(in_now) + SUM_W'(item_data.timeout_ms);
	assign new_exp = (sum > SUM_W'(TIME_MASK)) ? TIME_MASK : TIME_BITS'(sum);

	assign diff    = (rd_exp > now_q) ? (rd_exp - now_q) : '0;
	assign gap_ext = GAP_DW'(diff);
	assign gap     = (count_q == '0) ? '0 :
		(gap_ext > GAP_DW'(GAP_MAX)) ? GAP_MAX : GAP_W'(gap_ext);

	always_comb begin
		stat.clr_last    = (clr_q == MAP_AW'(HANDLES - 1));
		stat.is_tick     = (op_q == OP_TICK);
		stat.is_none     = (op_q == OP_NONE);
		stat.is_adjust   = (op_q == OP_ADJUST);
		stat.handle_ok   = (HCMP_W'(h_q) < HCMP_W'(HANDLES));
		stat.hit         = map_valid && (CNT_W'(map_slot) < count_q);
		stat.full        = (count_q >= CNT_W'(CAPACITY));
		stat.k_zero      = (k_q == '0);
		stat.less_parent = (e_exp_q < rd_exp);
		stat.moved       = (k_q != start_q);
		stat.l_ok        = (left_w < CHILD_W'(count_q));
		stat.t_is_k      = (t_q == k_q);
		stat.pops_left   = (count_q != '0) && (pops_q < POP_W'(MAX_POPS));
		stat.due         = (rd_exp <= now_q);
		stat.count_zero  = (count_q == '0);
	end

	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = k_q;
		heap_wdata = {e_exp_q, e_h_q};
		heap_re    = 1'b0;
		heap_raddr = '0;
		map_we     = 1'b0;
		map_waddr  = MAP_AW'(e_h_q);
		map_wdata  = {1'b1, k_q};
		map_re     = 1'b0;
		map_raddr  = MAP_AW'(h_q);
		case (cmd)
			CMD_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = '0;
			end
			CMD_MAP_READ: begin
				map_re = 1'b1;
			end
			CMD_READ_PARENT: begin
				heap_re    = 1'b1;
				heap_raddr = parent;
			end
			CMD_MOVE_PARENT: begin
				heap_we    = 1'b1;
				heap_wdata = heap_rdata_q;
				map_we     = 1'b1;
				map_waddr  = MAP_AW'(rd_h);
			end
			CMD_READ_LEFT: begin
				heap_re    = 1'b1;
				heap_raddr = IDX_W'(left_w);
			end
			CMD_LATCH_LEFT: begin
				heap_re    = 1'b1;
				heap_raddr = IDX_W'(right_w);
			end
			CMD_MOVE_CHILD: begin
				heap_we    = 1'b1;
				heap_wdata = {best_exp_q, best_h_q};
				map_we     = 1'b1;
				map_waddr  = MAP_AW'(best_h_q);
			end
			CMD_WRITE_E: begin
				heap_we = 1'b1;
				map_we  = 1'b1;
			end
			CMD_READ_ROOT: begin
				heap_re = 1'b1;
			end
			CMD_POP_ROOT: begin
				map_we    = 1'b1;
				map_waddr = MAP_AW'(rd_h);
				map_wdata = '0;
			end
			CMD_READ_LAST: begin
				heap_re    = 1'b1;
				heap_raddr = IDX_W'(count_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
			pops_q  <= '0;
		end else begin
			case (cmd)
				CMD_CLEAR:     clr_q <= clr_q + MAP_AW'(1);
				CMD_LOAD:      pops_q <= '0;
				CMD_START_ADD: count_q <= count_q + CNT_W'(1);
				CMD_POP_ROOT: begin
					count_q <= count_q - CNT_W'(1);
					pops_q  <= pops_q + POP_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q     <= item_data.operation;
				h_q      <= item_data.handle;
				exp_q    <= new_exp;
				now_q    <= in_now;
				status_q <= ST_OK;
			end
			CMD_START_ADJ: begin
				e_exp_q <= exp_q;
				e_h_q   <= h_q;
				k_q     <= map_slot;
				start_q <= map_slot;
			end
			CMD_START_ADD: begin
				e_exp_q <= exp_q;
				e_h_q   <= h_q;
				k_q     <= IDX_W'(count_q);
				start_q <= IDX_W'(count_q);
			end
			CMD_SET_ABSENT: status_q <= ST_ABSENT;
			CMD_SET_FULL:   status_q <= ST_FULL;
			CMD_MOVE_PARENT: k_q <= parent;
			CMD_LATCH_LEFT: begin
				if (rd_exp < e_exp_q) begin
					t_q        <= IDX_W'(left_w);
					best_exp_q <= rd_exp;
					best_h_q   <= rd_h;
				end else begin
					t_q        <= k_q;
					best_exp_q <= e_exp_q;
				end
			end
			CMD_LATCH_RIGHT: begin
				if (r_ok && (rd_exp < best_exp_q)) begin
					t_q        <= IDX_W'(right_w);
					best_exp_q <= rd_exp;
					best_h_q   <= rd_h;
				end
			end
			CMD_MOVE_CHILD: k_q <= t_q;
			CMD_POP_ROOT: begin
				res_q.kind           <= KIND_EXPIRED;
				res_q.expired_handle <= rd_h;
				res_q.time_to_next   <= '0;
				res_q.status         <= ST_OK;
				res_q.last           <= 1'b0;
			end
			CMD_START_DOWN: begin
				// The last entry fills the hole left at the root.
				e_exp_q <= rd_exp;
				e_h_q   <= rd_h;
				k_q     <= '0;
				start_q <= '0;
			end
			CMD_FINISH: begin
				res_q.kind           <= KIND_FINAL;
				res_q.expired_handle <= '0;
				res_q.time_to_next   <= gap;
				res_q.status         <= status_q;
				res_q.last           <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign result_data = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_pop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pops_q <= POP_W'(MAX_POPS))
		else $error("pop count above limit");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_WRITE_E) |-> (CNT_W'(k_q) < count_q))
		else $error("entry written outside the heap");

	a_child_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_MOVE_CHILD) |-> (t_q != k_q))
		else $error("sift down moved onto its own slot");

endmodule

// ----- hw/rtl/mhtq_ctrl.sv -----
// Controller state machine of the timer queue: sequences clearing, lookup,
// sift up, sift down, pops and result transactions. Uses mhtq_pkg.
module mhtq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output mhtq_pkg::cmd_t  cmd,
	input  mhtq_pkg::stat_t stat
);
	import mhtq_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_MAP_CHK,
		S_UP_RD,
		S_UP_CMP,
		S_UP_DONE,
		S_DN_L,
		S_DN_LCMP,
		S_DN_RCMP,
		S_DN_DEC,
		S_WRITE_E,
		S_POP_RD,
		S_POP_CHK,
		S_POP_EMIT,
		S_DN_START,
		S_FIN_RD,
		S_FIN_CALC,
		S_FIN_EMIT
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_POP_EMIT) || (state_q == S_FIN_EMIT);

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		case (state_q)
			S_CLEAR: begin
				cmd = CMD_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_tick) begin
					state_d = S_POP_RD;
				end else if (stat.is_none) begin
					state_d = S_FIN_RD;
				end else begin
					cmd     = CMD_MAP_READ;
					state_d = S_MAP_CHK;
				end
			end
			S_MAP_CHK: begin
				if (!stat.handle_ok) begin
					cmd     = CMD_SET_ABSENT;
					state_d = S_FIN_RD;
				end else if (stat.hit) begin
					cmd     = CMD_START_ADJ;
					state_d = S_UP_RD;
				end else if (stat.is_adjust) begin
					cmd     = CMD_SET_ABSENT;
					state_d = S_FIN_RD;
				end else if (stat.full) begin
					cmd     = CMD_SET_FULL;
					state_d = S_FIN_RD;
				end else begin
					cmd     = CMD_START_ADD;
					state_d = S_UP_RD;
				end
			end
			S_UP_RD: begin
				if (stat.k_zero) begin
					state_d = S_UP_DONE;
				end else begin
					cmd     = CMD_READ_PARENT;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.less_parent) begin
					cmd     = CMD_MOVE_PARENT;
					state_d = S_UP_RD;
				end else begin
					state_d = S_UP_DONE;
				end
			end
			S_UP_DONE: begin
				// An entry that did not rise may still have to sink.
				state_d = stat.moved ? S_WRITE_E : S_DN_L;
			end
			S_DN_L: begin
				if (stat.l_ok) begin
					cmd     = CMD_READ_LEFT;
					state_d = S_DN_LCMP;
				end else begin
					state_d = S_WRITE_E;
				end
			end
			S_DN_LCMP: begin
				cmd     = CMD_LATCH_LEFT;
				state_d = S_DN_RCMP;
			end
			S_DN_RCMP: begin
				cmd     = CMD_LATCH_RIGHT;
				state_d = S_DN_DEC;
			end
			S_DN_DEC: begin
				if (stat.t_is_k) begin
					state_d = S_WRITE_E;
				end else begin
					cmd     = CMD_MOVE_CHILD;
					state_d = S_DN_L;
				end
			end
			S_WRITE_E: begin
				cmd     = CMD_WRITE_E;
				state_d = stat.is_tick ? S_POP_RD : S_FIN_RD;
			end
			S_POP_RD: begin
				if (stat.pops_left) begin
					cmd     = CMD_READ_ROOT;
					state_d = S_POP_CHK;
				end else begin
					state_d = S_FIN_RD;
				end
			end
			S_POP_CHK: begin
				if (stat.due) begin
					cmd     = CMD_POP_ROOT;
					state_d = S_POP_EMIT;
				end else begin
					state_d = S_FIN_RD;
				end
			end
			S_POP_EMIT: begin
				// The last entry is fetched while the notice waits.
				cmd = CMD_READ_LAST;
				if (out_ready) state_d = stat.count_zero ? S_POP_RD : S_DN_START;
			end
			S_DN_START: begin
				cmd     = CMD_START_DOWN;
				state_d = S_DN_L;
			end
			S_FIN_RD: begin
				cmd     = CMD_READ_ROOT;
				state_d = S_FIN_CALC;
			end
			S_FIN_CALC: begin
				cmd     = CMD_FINISH;
				state_d = S_FIN_EMIT;
			end
			S_FIN_EMIT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_final_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN_EMIT && out_ready) |=> (state_q == S_IDLE))
		else $error("final transaction did not return to idle");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!in_ready && !out_valid))
		else $error("handshake active during map clear");

	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_LOAD) |-> (in_valid && in_ready))
		else $error("item loaded without a transaction");

endmodule
